@@ hdl/stroke_reveal_sequencer_defines.svh @@
// ---------------------------------------------------------------------------
// Stroke reveal sequencer assertion macros
// Concurrent assertion helpers that are compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef STROKE_REVEAL_SEQUENCER_DEFINES_SVH
`define STROKE_REVEAL_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication or plain property, checked outside reset.
`define SRS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SRS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SRS_ASSERT(lbl, clk, rst, prop, msg)
`define SRS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

@@ hdl/srs_pkg.sv @@
// ---------------------------------------------------------------------------
// Stroke reveal sequencer package
// Shared widths, command codes and the staged request record.
// ---------------------------------------------------------------------------
package srs_pkg;

  localparam int CMD_W     = 2;
  localparam int DT_W      = 16;
  localparam int EIDX_W    = 6;
  localparam int LEN_W     = 32;
  localparam int RATE_W    = 24;
  localparam int STEP_W    = RATE_W + DT_W;
  localparam int TIME_W    = 20;
  localparam int TOTAL_W   = 7;
  localparam int PHASE_W   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 24;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  // A request after the multiply stage.
  typedef struct packed {
    cmd_t                cmd;
    logic [DT_W-1:0]     elapsed_ms;
    logic [EIDX_W-1:0]   entry_index;
    logic [LEN_W-1:0]    entry_length;
    logic [STEP_W-1:0]   step;
  } item_t;

endpackage

@@ hdl/srs_if.sv @@
// ---------------------------------------------------------------------------
// Stroke reveal sequencer channels
// Valid/ready channels for requests and results.
// ---------------------------------------------------------------------------
interface srs_req_if
  import srs_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [DT_W-1:0]   elapsed_ms;
  logic [EIDX_W-1:0] entry_index;
  logic [LEN_W-1:0]  entry_length;

  modport source (output valid, command, elapsed_ms, entry_index, entry_length,
                  input ready);
  modport sink (input valid, command, elapsed_ms, entry_index, entry_length,
                output ready);
endinterface

interface srs_rsp_if
  import srs_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               redraw;
  logic [PHASE_W-1:0] phase_now;
  logic [EIDX_W-1:0]  stroke_now;
  logic [LEN_W-1:0]   span_from;
  logic [LEN_W-1:0]   span_to;
  logic               stroke_began;
  logic               stroke_landed;
  logic               glyph_finished;

  modport source (output valid, redraw, phase_now, stroke_now, span_from, span_to,
                  stroke_began, stroke_landed, glyph_finished,
                  input ready);
  modport sink (input valid, redraw, phase_now, stroke_now, span_from, span_to,
                stroke_began, stroke_landed, glyph_finished,
                output ready);
endinterface

@@ hdl/stroke_reveal_sequencer.sv @@
// ---------------------------------------------------------------------------
// Stroke reveal sequencer
// Phase sequencer for the stroke-by-stroke reveal of a glyph.
// ---------------------------------------------------------------------------
// The block takes one request per clock cycle, sustained, while results are
// accepted, and returns exactly one result per request: the front stage
// registers the request and forms the reveal step (speed times elapsed time),
// and the update applies it to the phase state and loads the output register.
// That rate is set by the state update, which reads the current stroke's length
// from a single-port-read memory; that memory is read every cycle at the stroke
// index the update is about to enter, so the length is ready when the next
// request arrives. A load that hits that same index in that cycle is
// forwarded around the memory. Stroke lengths are not cleared by reset and need
// no clearing pass; a stroke must be loaded before it is revealed.
`include "stroke_reveal_sequencer_defines.svh"

module stroke_reveal_sequencer
  import srs_pkg::*;
#(
  parameter int MAX_STROKES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  srs_req_if.sink              req,
  srs_rsp_if.source            rsp
);

  // Stroke index width and a count width that holds both the register and
  // the stroke limit.
  localparam int IW  = (MAX_STROKES > 1) ? $clog2(MAX_STROKES) : 1;
  localparam int CW0 = $clog2(MAX_STROKES + 1);
  localparam int CW  = (CW0 > TOTAL_W) ? CW0 : TOTAL_W;
  localparam int SUM_W = STEP_W + 1;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE   = 3'd0,
    PH_INTRO  = 3'd1,
    PH_REVEAL = 3'd2,
    PH_PAUSE  = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTRO_TIME    = 3'd0,
    REG_PAUSE_TIME    = 3'd1,
    REG_DONE_TIME     = 3'd2,
    REG_LOOP_ENABLE   = 3'd3,
    REG_REVEAL_PER_MS = 3'd4,
    REG_STROKE_TOTAL  = 3'd5
  } reg_idx_t;

  // Configuration registers.
  logic [TIME_W-1:0]  intro_time;
  logic [TIME_W-1:0]  pause_time;
  logic [TIME_W-1:0]  done_time;
  logic               loop_enable;
  logic [RATE_W-1:0]  reveal_per_ms;
  logic [TOTAL_W-1:0] stroke_total;

  // Sequencer state and its next value.
  phase_t            phase_reg,    phase_reg_next;
  logic [IW-1:0]     stroke_index, stroke_index_next;
  logic [LEN_W-1:0]  reveal_start, reveal_start_next;
  logic [LEN_W-1:0]  reveal_end,   reveal_end_next;
  logic [LEN_W-1:0]  phase_timer,  phase_timer_next;
  logic              redraw_next, began_next, landed_next, finished_next;

  // Output register.
  logic              out_valid;
  logic              out_redraw;
  phase_t            out_phase;
  logic [IW-1:0]     out_stroke;
  logic [LEN_W-1:0]  out_span_from;
  logic [LEN_W-1:0]  out_span_to;
  logic              out_began;
  logic              out_landed;
  logic              out_finished;

  // Front stage.
  logic   front_valid;
  item_t  front_item;
  logic   advance;

  // Stroke length memory and its forwarding register.
  logic             ram_we;
  logic [IW-1:0]    ram_waddr;
  logic [IW-1:0]    ram_raddr;
  logic [LEN_W-1:0] ram_rdata;
  logic             byp_valid;
  logic [LEN_W-1:0] byp_data;
  logic [LEN_W-1:0] cur_length;

  logic [CW-1:0]    count;
  logic [LEN_W:0]   timer_sum;
  logic [LEN_W-1:0] timer_sat;
  logic [SUM_W-1:0] span_sum;

  // The update runs whenever the output register is free or being emptied.
  assign advance = front_valid && (!out_valid || rsp.ready);

  srs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .reveal_per_ms (reveal_per_ms),
    .advance       (advance),
    .valid         (front_valid),
    .item          (front_item)
  );

  // Loads at or beyond the stroke limit are dropped.
  assign ram_we    = advance && (front_item.cmd == CMD_LOAD) &&
                     (32'(front_item.entry_index) < 32'(MAX_STROKES));
  assign ram_waddr = IW'(front_item.entry_index);
  assign ram_raddr = stroke_index_next;

  srs_ram #(
    .WIDTH (LEN_W),
    .DEPTH (MAX_STROKES)
  ) u_lengths (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (front_item.entry_length),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The memory returns old data on a same-address write, so that write is
  // caught here and replaces the read.
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else begin
      byp_valid <= ram_we && (ram_waddr == ram_raddr);
    end
    byp_data <= front_item.entry_length;
  end

  assign cur_length = byp_valid ? byp_data : ram_rdata;

  // A stroke count above the limit counts as the limit.
  assign count = (CW'(stroke_total) > CW'(MAX_STROKES)) ? CW'(MAX_STROKES)
                                                         : CW'(stroke_total);

  assign timer_sum = {1'b0, phase_timer} + (LEN_W + 1)'(front_item.elapsed_ms);
  assign timer_sat = timer_sum[LEN_W] ? {LEN_W{1'b1}} : timer_sum[LEN_W-1:0];
  assign span_sum  = SUM_W'(reveal_end) + SUM_W'(front_item.step);

  always_comb begin
    phase_reg_next    = phase_reg;
    stroke_index_next = stroke_index;
    reveal_start_next = reveal_start;
    reveal_end_next   = reveal_end;
    phase_timer_next  = phase_timer;
    redraw_next       = 1'b0;
    began_next        = 1'b0;
    landed_next       = 1'b0;
    finished_next     = 1'b0;
    if (advance) begin
      case (front_item.cmd)
        CMD_LOAD: begin
          // Only the memory changes.
        end
        CMD_RESTART: begin
          phase_reg_next    = (count != '0) ? PH_INTRO : PH_IDLE;
          stroke_index_next = '0;
          reveal_start_next = '0;
          reveal_end_next   = '0;
          phase_timer_next  = '0;
          redraw_next       = 1'b1;
        end
        CMD_TICK: begin
          // A tick of zero time, in idle, or without a glyph does nothing.
          if ((front_item.elapsed_ms != '0) && (phase_reg != PH_IDLE) &&
              (count != '0)) begin
            case (phase_reg)
              PH_INTRO: begin
                phase_timer_next = timer_sat;
                if (timer_sat >= LEN_W'(intro_time)) begin
                  phase_reg_next    = PH_REVEAL;
                  stroke_index_next = '0;
                  reveal_start_next = '0;
                  reveal_end_next   = '0;
                  phase_timer_next  = '0;
                  began_next        = 1'b1;
                  redraw_next       = 1'b1;
                end
              end
              PH_REVEAL: begin
                reveal_start_next = reveal_end;
                redraw_next       = 1'b1;
                if (span_sum >= SUM_W'(cur_length)) begin
                  reveal_end_next  = cur_length;
                  phase_reg_next   = PH_PAUSE;
                  phase_timer_next = '0;
                  landed_next      = 1'b1;
                end else begin
                  reveal_end_next = span_sum[LEN_W-1:0];
                end
              end
              PH_PAUSE: begin
                phase_timer_next = timer_sat;
                if (timer_sat >= LEN_W'(pause_time)) begin
                  redraw_next = 1'b1;
                  if ((CW + 1)'(stroke_index) + (CW + 1)'(1) < (CW + 1)'(count)) begin
                    phase_reg_next    = PH_REVEAL;
                    stroke_index_next = stroke_index + IW'(1);
                    reveal_start_next = '0;
                    reveal_end_next   = '0;
                    phase_timer_next  = '0;
                    began_next        = 1'b1;
                  end else begin
                    // Last stroke, or the count was lowered under us.
                    phase_reg_next   = PH_DONE;
                    phase_timer_next = '0;
                    finished_next    = 1'b1;
                  end
                end
              end
              PH_DONE: begin
                phase_timer_next = timer_sat;
                if (loop_enable && (timer_sat >= LEN_W'(done_time))) begin
                  phase_reg_next    = PH_INTRO;
                  stroke_index_next = '0;
                  reveal_start_next = '0;
                  reveal_end_next   = '0;
                  phase_timer_next  = '0;
                  redraw_next       = 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        default: begin
          // The reserved command does nothing.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      intro_time    <= '0;
      pause_time    <= '0;
      done_time     <= '0;
      loop_enable   <= 1'b0;
      reveal_per_ms <= '0;
      stroke_total  <= '0;
      phase_reg     <= PH_IDLE;
      stroke_index  <= '0;
      reveal_start  <= '0;
      reveal_end    <= '0;
      phase_timer   <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_INTRO_TIME:    intro_time    <= cfg_data[TIME_W-1:0];
          REG_PAUSE_TIME:    pause_time    <= cfg_data[TIME_W-1:0];
          REG_DONE_TIME:     done_time     <= cfg_data[TIME_W-1:0];
          REG_LOOP_ENABLE:   loop_enable   <= cfg_data[0];
          REG_REVEAL_PER_MS: reveal_per_ms <= cfg_data[RATE_W-1:0];
          REG_STROKE_TOTAL:  stroke_total  <= cfg_data[TOTAL_W-1:0];
          default: begin
          end
        endcase
      end
      phase_reg    <= phase_reg_next;
      stroke_index <= stroke_index_next;
      reveal_start <= reveal_start_next;
      reveal_end   <= reveal_end_next;
      phase_timer  <= phase_timer_next;
      if (advance) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      out_redraw    <= redraw_next;
      out_phase     <= phase_reg_next;
      out_stroke    <= stroke_index_next;
      out_span_from <= reveal_start_next;
      out_span_to   <= reveal_end_next;
      out_began     <= began_next;
      out_landed    <= landed_next;
      out_finished  <= finished_next;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.redraw         = out_redraw;
  assign rsp.phase_now      = out_phase;
  assign rsp.stroke_now     = EIDX_W'(out_stroke);
  assign rsp.span_from      = out_span_from;
  assign rsp.span_to        = out_span_to;
  assign rsp.stroke_began   = out_began;
  assign rsp.stroke_landed  = out_landed;
  assign rsp.glyph_finished = out_finished;

  // A new stroke always starts revealing from nothing.
  `SRS_ASSERT(a_began_reveal, clk, rst, out_valid && out_began |-> out_phase == PH_REVEAL && out_span_to == '0, "stroke began outside reveal or with a span")
  `SRS_ASSERT(a_landed_pause, clk, rst, out_valid && out_landed |-> out_phase == PH_PAUSE, "stroke landed without entering pause")
  `SRS_ASSERT(a_finished_done, clk, rst, out_valid && out_finished |-> out_phase == PH_DONE, "glyph finished without entering done")
  `SRS_ASSERT(a_one_pulse, clk, rst, out_valid |-> $onehot0({out_began, out_landed, out_finished}), "more than one event pulse in a result")
  `SRS_ASSERT_NEXT(a_load_quiet, clk, rst, advance && front_item.cmd == CMD_LOAD, out_valid && !out_redraw && $stable(phase_reg), "length load disturbed the sequence")

endmodule

@@ hdl/srs_ram.sv @@
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered, read-first data.
// ---------------------------------------------------------------------------
module srs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/srs_front.sv @@
// ---------------------------------------------------------------------------
// Stroke reveal sequencer front stage
// Registers each request and forms the reveal step for it.
// ---------------------------------------------------------------------------
module srs_front
  import srs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  srs_req_if.sink           req,
  input  logic [RATE_W-1:0] reveal_per_ms,
  input  logic              advance,
  output logic              valid,
  output item_t             item
);

  // The stage refills whenever it is empty or its request moves on.
  assign req.ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (req.ready) begin
      valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      item.cmd          <= cmd_t'(req.command);
      item.elapsed_ms   <= req.elapsed_ms;
      item.entry_index  <= req.entry_index;
      item.entry_length <= req.entry_length;
      item.step         <= STEP_W'(reveal_per_ms) * STEP_W'(req.elapsed_ms);
    end
  end

endmodule
